// ===== hdl/ifmt_pkg.sv =====
// ----------------------------------------------------------------------------
// ifmt_pkg: shared definitions for the integer field formatter
// Conversion codes, flag positions, counter widths, the controller/datapath
// command and status structures and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package ifmt_pkg;

  localparam int MAX_WIDTH_DEF = 32;
  localparam int MAX_PREC_DEF  = 32;
  localparam int DIGIT_SLOTS   = 16;

  // Counts of characters in one conversion; holds up to 2*63 + 1.
  localparam int CNT_W = 7;
  localparam int ND_W  = $clog2(DIGIT_SLOTS + 1);

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  // Conversion codes
  localparam logic [2:0] ACT_D   = 3'd0;
  localparam logic [2:0] ACT_U   = 3'd1;
  localparam logic [2:0] ACT_LX  = 3'd2;
  localparam logic [2:0] ACT_UX  = 3'd3;
  localparam logic [2:0] ACT_B   = 3'd4;
  localparam logic [2:0] ACT_P   = 3'd5;
  localparam logic [2:0] ACT_C   = 3'd6;
  localparam logic [2:0] ACT_PCT = 3'd7;

  // Flag bit positions
  localparam int FLG_SPACE = 0;
  localparam int FLG_PLUS  = 1;
  localparam int FLG_MINUS = 2;
  localparam int FLG_ZERO  = 3;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] LOWER_BIT  = 8'h20;

  // Multiply-and-shift reciprocal for division by ten of a 16-bit value.
  localparam logic [15:0] RECIP10   = 16'd52429;
  localparam int          RECIP10_S = 19;

  typedef struct packed {
    logic load;
    logic step;
    logic plan_a;
    logic plan_b;
    logic emit;
  } ifmt_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic emit_last;
    logic out_free;
  } ifmt_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] c;
    case (d)
      4'd0:    c = 8'h30;
      4'd1:    c = 8'h31;
      4'd2:    c = 8'h32;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h34;
      4'd5:    c = 8'h35;
      4'd6:    c = 8'h36;
      4'd7:    c = 8'h37;
      4'd8:    c = 8'h38;
      4'd9:    c = 8'h39;
      4'd10:   c = 8'h41;
      4'd11:   c = 8'h42;
      4'd12:   c = 8'h43;
      4'd13:   c = 8'h44;
      4'd14:   c = 8'h45;
      default: c = 8'h46;
    endcase
    if (lower) begin
      c = c | LOWER_BIT;
    end
    return c;
  endfunction

endpackage

// ===== hdl/ifmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ifmt_ctrl: sequencing controller
// Walks one request through load, digit extraction, two layout steps and
// character emission, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module ifmt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output ifmt_pkg::ifmt_cmd_t cmd,
  input  ifmt_pkg::ifmt_sts_t sts
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CONV   = 5'b00010,
    ST_PLAN_A = 5'b00100,
    ST_PLAN_B = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == ST_IDLE) && in_tvalid;
    cmd.step   = (state_r == ST_CONV) && !sts.conv_done;
    cmd.plan_a = (state_r == ST_PLAN_A);
    cmd.plan_b = (state_r == ST_PLAN_B);
    cmd.emit   = (state_r == ST_EMIT) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts.conv_done) begin
          state_nxt = ST_PLAN_A;
        end
      end
      ST_PLAN_A: state_nxt = ST_PLAN_B;
      ST_PLAN_B: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free && sts.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/ifmt_dp.sv =====
// ----------------------------------------------------------------------------
// ifmt_dp: formatter datapath
// Holds the request, extracts one digit per step into a digit shift line,
// lays out the padding, sign, zero and digit segments, and drives the
// result register one character at a time.
// ----------------------------------------------------------------------------
module ifmt_dp #(
  parameter int MAX_WIDTH = ifmt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PREC  = ifmt_pkg::MAX_PREC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ifmt_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  ifmt_pkg::ifmt_cmd_t                 cmd,
  output ifmt_pkg::ifmt_sts_t                 sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ifmt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tlast,
  output logic                                out_tuser
);

  localparam int CW = ifmt_pkg::CNT_W;
  localparam int NW = ifmt_pkg::ND_W;
  localparam int DS = ifmt_pkg::DIGIT_SLOTS;

  // Request fields
  logic [2:0]  in_action;
  logic [15:0] in_value;
  logic [3:0]  in_flags;
  logic [5:0]  in_width;
  logic        in_given;
  logic [5:0]  in_prec;

  assign in_action = in_tdata[2:0];
  assign in_value  = in_tdata[18:3];
  assign in_flags  = in_tdata[22:19];
  assign in_width  = in_tdata[28:23];
  assign in_given  = in_tdata[29];
  assign in_prec   = in_tdata[35:30];

  logic [2:0]  action_r;
  logic [15:0] mag_r;
  logic [3:0]  flags_r;
  logic [5:0]  width_r;
  logic        given_r;
  logic [5:0]  prec_r;
  logic [7:0]  chr_r;
  logic [7:0]  sign_chr_r;
  logic        has_sign_r;
  logic [NW-1:0] nd_r;
  logic [3:0]  dig_r [DS];

  logic [CW-1:0] left_r, zeros_r, right_r;
  logic [7:0]    pad_chr_r;
  logic [CW-1:0] b1_r, b2_r, b3_r, b4_r, n_r;
  logic [CW-1:0] k_r;

  logic          out_valid_r;
  logic [7:0]    out_chr_r;
  logic          out_has_r;
  logic          out_last_r;
  logic [5:0]    out_cnt_r;

  // ---------------- load ----------------
  logic [5:0]  ld_width, ld_prec;
  logic        ld_given;
  logic [15:0] ld_mag;
  logic [7:0]  ld_sign_chr;
  logic        ld_has_sign;

  always_comb begin
    ld_width    = (in_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : in_width;
    ld_prec     = (in_prec > 6'(MAX_PREC)) ? 6'(MAX_PREC) : in_prec;
    ld_given    = in_given;
    ld_mag      = in_value;
    ld_sign_chr = ifmt_pkg::CH_SPACE;
    ld_has_sign = 1'b0;
    if (in_action == ifmt_pkg::ACT_P) begin
      ld_width = 6'd4;
      ld_prec  = 6'd4;
      ld_given = 1'b1;
    end
    if (in_action == ifmt_pkg::ACT_D) begin
      if (in_value[15]) begin
        ld_mag      = (~in_value) + 16'd1;
        ld_sign_chr = ifmt_pkg::CH_MINUS;
        ld_has_sign = 1'b1;
      end else if (in_flags[ifmt_pkg::FLG_PLUS]) begin
        ld_sign_chr = ifmt_pkg::CH_PLUS;
        ld_has_sign = 1'b1;
      end else if (in_flags[ifmt_pkg::FLG_SPACE]) begin
        ld_sign_chr = ifmt_pkg::CH_SPACE;
        ld_has_sign = 1'b1;
      end
    end
  end

  // ---------------- digit step ----------------
  logic [31:0] q10_prod;
  logic [15:0] q10;
  logic [15:0] mag_nxt;
  logic [3:0]  dig_new;
  logic        numeric;

  assign numeric  = (action_r != ifmt_pkg::ACT_C) && (action_r != ifmt_pkg::ACT_PCT);
  assign q10_prod = mag_r * ifmt_pkg::RECIP10;
  assign q10      = 16'(q10_prod >> ifmt_pkg::RECIP10_S);

  always_comb begin
    case (action_r)
      ifmt_pkg::ACT_LX, ifmt_pkg::ACT_UX, ifmt_pkg::ACT_P: begin
        dig_new = mag_r[3:0];
        mag_nxt = mag_r >> 4;
      end
      ifmt_pkg::ACT_B: begin
        dig_new = {3'd0, mag_r[0]};
        mag_nxt = mag_r >> 1;
      end
      default: begin
        dig_new = 4'(mag_r - ((q10 << 3) + (q10 << 1)));
        mag_nxt = q10;
      end
    endcase
  end

  assign sts.conv_done = (mag_r == 16'd0) || (nd_r == NW'(DS)) || !numeric;

  // ---------------- layout, first step ----------------
  logic [CW-1:0] numw, len, padw, pa_left, pa_zeros, pa_right, rep;
  logic [7:0]    pa_pad;
  logic          zero_fill;

  always_comb begin
    numw = given_r ? CW'(prec_r) : CW'(1);
    if (numw < CW'(nd_r)) begin
      numw = CW'(nd_r);
    end
    len       = numw + CW'(has_sign_r);
    padw      = (CW'(width_r) > len) ? (CW'(width_r) - len) : '0;
    pa_left   = flags_r[ifmt_pkg::FLG_MINUS] ? '0 : padw;
    pa_right  = flags_r[ifmt_pkg::FLG_MINUS] ? padw : '0;
    pa_zeros  = numw - CW'(nd_r);
    zero_fill = flags_r[ifmt_pkg::FLG_ZERO] && !given_r;
    pa_pad    = ifmt_pkg::CH_SPACE;
    if (zero_fill) begin
      pa_zeros = pa_zeros + pa_left;
      pa_left  = '0;
    end
    rep = (given_r && (prec_r > 6'd1)) ? CW'(prec_r) : CW'(1);
    if (action_r == ifmt_pkg::ACT_C) begin
      pa_left  = '0;
      pa_zeros = '0;
      pa_right = rep;
      pa_pad   = chr_r;
    end else if (action_r == ifmt_pkg::ACT_PCT) begin
      pa_left  = '0;
      pa_zeros = '0;
      pa_right = CW'(1);
      pa_pad   = ifmt_pkg::CH_PERCENT;
    end
  end

  // ---------------- emission ----------------
  logic [7:0] em_chr;
  logic       em_digit;
  logic       em_empty;
  logic       em_last;

  assign em_empty = (n_r == '0);
  assign em_last  = em_empty || (k_r == (n_r - CW'(1)));
  assign em_digit = (k_r >= b3_r) && (k_r < b4_r);

  always_comb begin
    if (em_empty) begin
      em_chr = 8'h00;
    end else if (k_r < b1_r) begin
      em_chr = ifmt_pkg::CH_SPACE;
    end else if (k_r < b2_r) begin
      em_chr = sign_chr_r;
    end else if (k_r < b3_r) begin
      em_chr = ifmt_pkg::CH_ZERO;
    end else if (em_digit) begin
      em_chr = ifmt_pkg::digit_char(dig_r[DS-1], action_r == ifmt_pkg::ACT_LX);
    end else begin
      em_chr = pad_chr_r;
    end
  end

  assign sts.emit_last = em_last;
  assign sts.out_free  = !out_valid_r || out_tready;

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r   <= in_action;
      mag_r      <= ld_mag;
      flags_r    <= in_flags;
      width_r    <= ld_width;
      given_r    <= ld_given;
      prec_r     <= ld_prec;
      chr_r      <= in_value[7:0];
      sign_chr_r <= ld_sign_chr;
      has_sign_r <= ld_has_sign;
      nd_r       <= '0;
      k_r        <= '0;
    end
    if (cmd.step) begin
      mag_r <= mag_nxt;
      nd_r  <= nd_r + NW'(1);
    end
    if (cmd.plan_a) begin
      left_r    <= pa_left;
      zeros_r   <= pa_zeros;
      right_r   <= pa_right;
      pad_chr_r <= pa_pad;
    end
    if (cmd.plan_b) begin
      b1_r <= left_r;
      b2_r <= left_r + CW'(has_sign_r);
      b3_r <= left_r + CW'(has_sign_r) + zeros_r;
      b4_r <= left_r + CW'(has_sign_r) + zeros_r + CW'(nd_r);
      n_r  <= left_r + CW'(has_sign_r) + zeros_r + CW'(nd_r) + right_r;
    end
    if (cmd.emit) begin
      k_r        <= k_r + CW'(1);
      out_chr_r  <= em_chr;
      out_has_r  <= !em_empty;
      out_last_r <= em_last;
      out_cnt_r  <= em_last ? n_r[5:0] : 6'd0;
    end
  end

  // Digits enter at the top and move down during extraction; the most
  // significant digit ends at the top and leaves first during emission.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      dig_r[DS-1] <= dig_new;
      for (int i = 0; i < DS - 1; i++) begin
        dig_r[i] <= dig_r[i+1];
      end
    end else if (cmd.emit && em_digit) begin
      dig_r[0] <= 4'd0;
      for (int i = 1; i < DS; i++) begin
        dig_r[i] <= dig_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_chr_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_has_r;

endmodule

// ===== hdl/integer_field_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_field_formatter: 16-bit integer conversion to ASCII characters
// One conversion request in, its characters out one per result.
// ----------------------------------------------------------------------------
// Usage:
//   A request arrives on the in_ stream and carries the conversion, the
//   value, the flags, the field width and the precision. The characters of
//   the conversion leave on the out_ stream, one per transfer, in order;
//   out_tlast marks the final one, which also carries the character count.
//   A conversion that produces no characters gives one transfer with
//   out_tuser low, a zero character and out_tlast high.
//   Timing: after acceptance the digit extractor produces one digit per
//   cycle (up to 16 for binary, 5 for decimal, 4 for hex) until the
//   extraction is seen to finish, the PLAN_A and PLAN_B steps lay out the
//   field, then one character leaves per cycle while the receiver keeps
//   up. The next request is taken while the last character still waits in
//   the result register.
//   A stalled receiver holds the current character and pauses emission.
//   After reset both streams are empty and in_tready is high.
// ----------------------------------------------------------------------------
module integer_field_formatter #(
  parameter int MAX_WIDTH = ifmt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PREC  = ifmt_pkg::MAX_PREC_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // action[2:0], value[18:3], format_flags[22:19], field_width[28:23],
  // precision_given[29], precision[35:30], zero fill above
  input  logic [ifmt_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_char[7:0], char_count[13:8], zero fill above
  output logic [ifmt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,
  // has_char[0]
  output logic                             out_tuser
);

  ifmt_pkg::ifmt_cmd_t cmd;
  ifmt_pkg::ifmt_sts_t sts;

  ifmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ifmt_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_PREC  (MAX_PREC)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
